@@ rtl/core/arp_cache_table_defines.svh @@
// ----------------------------------------------------------------------------
// arp cache table assertion macros
// shared concurrent assertion forms, all reset-qualified on the active-low reset argument
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_TABLE_DEFINES_SVH
`define ARP_CACHE_TABLE_DEFINES_SVH

// same-cycle implication
`define ARPC_ASSERT_IMP(lbl, clk_s, rst_ns, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ARPC_ASSERT_NXT(lbl, clk_s, rst_ns, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// arpc_pkg
// shared widths, codes, types and the victim lfsr step
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int DEF_TABLE_ENTRIES = 32;

	localparam int ACTION_W = 2;
	localparam int IP_W     = 32;
	localparam int MAC_W    = 48;
	localparam int SLOT_W   = 5;
	localparam int AGE_W    = 8;
	localparam int LFSR_W   = 16;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;

	// register index (paddr word bits)
	localparam logic [APB_ADDR_W-3:0] REG_ENTRY_TIMEOUT = 1'b0;

	localparam logic [AGE_W-1:0]  TIMEOUT_RESET = 8'd15;
	localparam logic [AGE_W-1:0]  AGE_MAX       = 8'hFF;
	localparam logic [LFSR_W-1:0] LFSR_SEED     = 16'hACE1;

	// write strobes into the entry store
	typedef struct packed {
		logic tag_we;
		logic age_we;
	} store_ctl_t;

	// fibonacci lfsr, taps 16,14,13,11, shifting right
	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
		logic fb;
		fb = v[0] ^ v[2] ^ v[3] ^ v[5];
		return {fb, v[LFSR_W-1:1]};
	endfunction

endpackage

@@ rtl/core/arpc_ifs.sv @@
// ----------------------------------------------------------------------------
// arpc request and response channels
// valid/ready streams carrying the cache requests and their results
// ----------------------------------------------------------------------------
interface arpc_req_if;
	import arpc_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [IP_W-1:0]     ip_addr;
	logic [MAC_W-1:0]    new_mac;

	modport source (output valid, action, ip_addr, new_mac, input ready);
	modport sink   (input valid, action, ip_addr, new_mac, output ready);
endinterface

interface arpc_rsp_if;
	import arpc_pkg::*;

	logic              valid;
	logic              ready;
	logic              hit;
	logic [MAC_W-1:0]  found_mac;
	logic [SLOT_W-1:0] slot_used;

	modport source (output valid, hit, found_mac, slot_used, input ready);
	modport sink   (input valid, hit, found_mac, slot_used, output ready);
endinterface

@@ rtl/core/arpc_store.sv @@
// ----------------------------------------------------------------------------
// arpc_store
// entry memories: address/mac tags and ages, one write and one read port
// ----------------------------------------------------------------------------
module arpc_store #(
	parameter int ENTRIES = arpc_pkg::DEF_TABLE_ENTRIES,
	localparam int IDX_W = $clog2(ENTRIES)
) (
	input  logic                         clk,
	input  arpc_pkg::store_ctl_t         ctl,
	input  logic [IDX_W-1:0]             wr_addr,
	input  logic [arpc_pkg::IP_W-1:0]    wr_ip,
	input  logic [arpc_pkg::MAC_W-1:0]   wr_mac,
	input  logic [arpc_pkg::AGE_W-1:0]   wr_age,
	input  logic [IDX_W-1:0]             rd_addr,
	output logic [arpc_pkg::IP_W-1:0]    rd_ip,
	output logic [arpc_pkg::MAC_W-1:0]   rd_mac,
	output logic [arpc_pkg::AGE_W-1:0]   rd_age
);
	import arpc_pkg::*;

	logic [IP_W+MAC_W-1:0] tag_mem [ENTRIES];
	logic [AGE_W-1:0]      age_mem [ENTRIES];
	logic [IP_W+MAC_W-1:0] rd_tag_q;
	logic [AGE_W-1:0]      rd_age_q;

	always_ff @(posedge clk) begin
		if (ctl.tag_we) begin
			tag_mem[wr_addr] <= {wr_ip, wr_mac};
		end
		rd_tag_q <= tag_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.age_we) begin
			age_mem[wr_addr] <= wr_age;
		end
		rd_age_q <= age_mem[rd_addr];
	end

	assign rd_ip  = rd_tag_q[IP_W+MAC_W-1:MAC_W];
	assign rd_mac = rd_tag_q[MAC_W-1:0];
	assign rd_age = rd_age_q;

endmodule

@@ rtl/core/arpc_remainder.sv @@
// ----------------------------------------------------------------------------
// arpc_remainder
// remainder of a 16-bit value by the table size, by reciprocal multiply
// ----------------------------------------------------------------------------
module arpc_remainder #(
	parameter int DIVISOR = arpc_pkg::DEF_TABLE_ENTRIES,
	localparam int IDX_W = $clog2(DIVISOR)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [arpc_pkg::LFSR_W-1:0]   value,
	output logic                          done,
	output logic [IDX_W-1:0]              rem
);
	import arpc_pkg::*;

	// quotient = (v * RECIP) >> SHIFT, exact for every 16-bit v
	localparam int     SHIFT   = LFSR_W + IDX_W;
	localparam int     RECIP_W = LFSR_W + 1;
	localparam int     PROD_W  = LFSR_W + RECIP_W;
	localparam longint RECIP_L = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
	localparam logic [LFSR_W-1:0]  DIV_K = LFSR_W'(DIVISOR);

	logic              vld_s1;
	logic              vld_s2;
	logic              vld_s3;
	logic [LFSR_W-1:0] val_s1;
	logic [LFSR_W-1:0] val_s2;
	logic [LFSR_W-1:0] quo_s2;
	logic [IDX_W-1:0]  rem_s3;
	logic [PROD_W-1:0] prod;
	logic [LFSR_W-1:0] back;

	assign prod = PROD_W'(val_s1) * PROD_W'(RECIP);
	assign back = quo_s2 * DIV_K;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// datapath: multiply, then multiply back and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			val_s1 <= value;
		end
		if (vld_s1) begin
			quo_s2 <= LFSR_W'(prod >> SHIFT);
			val_s2 <= val_s1;
		end
		if (vld_s2) begin
			rem_s3 <= IDX_W'(val_s2 - back);
		end
	end

	assign done = vld_s3;
	assign rem  = rem_s3;

endmodule

@@ rtl/core/arp_cache_table.sv @@
// ----------------------------------------------------------------------------
// arp_cache_table: ipv4 to mac cache with aging and random replacement
// lookup and tick: the scan reads one entry of the entry memory per cycle, then the
//   result goes to the output register; a new request is taken only in the idle state
// insert: scans the same way, and on a full table also passes through the remainder unit
// async reset clears all valid bits, restores timeout 15 and lfsr seed 16'hACE1
// ----------------------------------------------------------------------------
module arp_cache_table #(
	parameter int TABLE_ENTRIES = arpc_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	arpc_req_if.sink                           req,
	arpc_rsp_if.source                         rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [arpc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [arpc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [arpc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);
	import arpc_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]              state_q;

	// latched request
	logic [ACTION_W-1:0]     op_q;
	logic [IP_W-1:0]         ip_q;
	logic [MAC_W-1:0]        mac_q;

	// scan address counter and read pipeline
	logic [CNT_W-1:0]        cnt_q;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;

	// scan results
	logic                    found_q;
	logic [MAC_W-1:0]        found_mac_q;
	logic                    free_found_q;
	logic [IDX_W-1:0]        free_idx_q;
	logic [IDX_W-1:0]        slot_q;
	logic [SLOT_W-1:0]       res_slot_q;

	// table state held in flops
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [LFSR_W-1:0]       lfsr_q;
	logic [AGE_W-1:0]        timeout_q;

	// output register
	logic                    out_valid_q;
	logic                    out_hit_q;
	logic [MAC_W-1:0]        out_mac_q;
	logic [SLOT_W-1:0]       out_slot_q;

	// store interface
	store_ctl_t              st_ctl;
	logic [IDX_W-1:0]        st_wr_addr;
	logic [AGE_W-1:0]        st_wr_age;
	logic [IP_W-1:0]         rd_ip;
	logic [MAC_W-1:0]        rd_mac;
	logic [AGE_W-1:0]        rd_age;

	// remainder unit
	logic                    mod_start;
	logic                    mod_done;
	logic [IDX_W-1:0]        mod_rem;
	logic [LFSR_W-1:0]       lfsr_step;

	logic                    req_fire;
	logic                    scan_issue;
	logic                    scan_end;
	logic                    entry_live;
	logic                    ip_match;
	logic [AGE_W-1:0]        age_inc;
	logic                    out_free;
	logic                    cfg_wr;
	logic [APB_ADDR_W-3:0]   cfg_idx;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;

	// scan: issue one read per cycle, evaluate the returned entry in the following cycle
	assign scan_issue = (state_q == ST_SCAN) && (cnt_q < CNT_W'(TABLE_ENTRIES));
	assign scan_end   = (state_q == ST_SCAN) && !scan_issue && !rd_vld_s1;

	assign entry_live = valid_q[rd_idx_s1];
	assign ip_match   = (rd_ip == ip_q);
	// age saturates at its top code
	assign age_inc    = (rd_age == AGE_MAX) ? AGE_MAX : rd_age + 8'd1;

	// full-table insert picks its victim from the advanced lfsr
	assign lfsr_step = lfsr_next(lfsr_q);
	assign mod_start = scan_end && (op_q == ACT_INSERT) && !free_found_q;

	assign out_free = !out_valid_q || rsp.ready;

	// entry store writes: insert writes the whole slot, tick rewrites ages in scan order
	always_comb begin
		st_ctl.tag_we = (state_q == ST_WRITE);
		st_ctl.age_we = (state_q == ST_WRITE) ||
			((state_q == ST_SCAN) && rd_vld_s1 && (op_q == ACT_TICK));
		st_wr_addr    = (state_q == ST_WRITE) ? slot_q : rd_idx_s1;
		st_wr_age     = (state_q == ST_WRITE) ? '0 : age_inc;
	end

	arpc_store #(
		.ENTRIES (TABLE_ENTRIES)
	) u_store (
		.clk     (clk),
		.ctl     (st_ctl),
		.wr_addr (st_wr_addr),
		.wr_ip   (ip_q),
		.wr_mac  (mac_q),
		.wr_age  (st_wr_age),
		.rd_addr (cnt_q[IDX_W-1:0]),
		.rd_ip   (rd_ip),
		.rd_mac  (rd_mac),
		.rd_age  (rd_age)
	);

	arpc_remainder #(
		.DIVISOR (TABLE_ENTRIES)
	) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (lfsr_step),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			lfsr_q    <= LFSR_SEED;
		end else begin
			rd_vld_s1 <= scan_issue;
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						cnt_q <= '0;
						// unused action code completes with an all-zero result
						if (req.action == ACT_LOOKUP || req.action == ACT_INSERT ||
							req.action == ACT_TICK) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (scan_end) begin
						if (op_q == ACT_INSERT) begin
							if (free_found_q) begin
								state_q <= ST_WRITE;
							end else begin
								lfsr_q  <= lfsr_step;
								state_q <= ST_MOD;
							end
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request latch, scan evaluation and result collection
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q         <= req.action;
			ip_q         <= req.ip_addr;
			mac_q        <= req.new_mac;
			found_q      <= 1'b0;
			found_mac_q  <= '0;
			free_found_q <= 1'b0;
			res_slot_q   <= '0;
		end
		if (scan_issue) begin
			rd_idx_s1 <= cnt_q[IDX_W-1:0];
		end
		if ((state_q == ST_SCAN) && rd_vld_s1) begin
			// lowest valid match wins
			if (op_q == ACT_LOOKUP && !found_q && entry_live && ip_match) begin
				found_q     <= 1'b1;
				found_mac_q <= rd_mac;
			end
			// lowest free slot wins
			if (op_q == ACT_INSERT && !free_found_q && !entry_live) begin
				free_found_q <= 1'b1;
				free_idx_q   <= rd_idx_s1;
			end
		end
		if (scan_end && free_found_q) begin
			slot_q <= free_idx_q;
		end
		if ((state_q == ST_MOD) && mod_done) begin
			slot_q <= mod_rem;
		end
		if (state_q == ST_WRITE) begin
			res_slot_q <= SLOT_W'(slot_q);
		end
	end

	// valid bits: cleared by aging, set by insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if ((state_q == ST_SCAN) && rd_vld_s1 && (op_q == ACT_TICK) &&
				(age_inc > timeout_q)) begin
				valid_q[rd_idx_s1] <= 1'b0;
			end
			if (state_q == ST_WRITE) begin
				valid_q[slot_q] <= 1'b1;
			end
		end
	end

	// output register, decoupled from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_hit_q  <= found_q;
			out_mac_q  <= found_mac_q;
			out_slot_q <= res_slot_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.hit       = out_hit_q;
	assign rsp.found_mac = out_mac_q;
	assign rsp.slot_used = out_slot_q;

	// configuration port, zero wait states
	assign pready  = 1'b1;
	assign cfg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr && (cfg_idx == REG_ENTRY_TIMEOUT)) begin
			timeout_q <= pwdata[AGE_W-1:0];
		end
	end

	assign prdata = (cfg_idx == REG_ENTRY_TIMEOUT) ? APB_DATA_W'(timeout_q) : '0;

endmodule

@@ rtl/core/arpc_checker.sv @@
// ----------------------------------------------------------------------------
// arpc_checker
// port-level checks on the cache table, bound to the top level
// ----------------------------------------------------------------------------
`include "arp_cache_table_defines.svh"

module arpc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic                           rsp_hit,
	input logic [arpc_pkg::MAC_W-1:0]     rsp_found_mac,
	input logic [arpc_pkg::SLOT_W-1:0]    rsp_slot_used
);
	import arpc_pkg::*;

	// one request at a time: busy right after an accept
	`ARPC_ASSERT_NXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)

	// a stalled result holds
	`ARPC_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_found_mac) && $stable(rsp_slot_used))

	// a miss carries no mac
	`ARPC_ASSERT_IMP(a_miss_no_mac, clk, arst_n, rsp_valid && !rsp_hit, rsp_found_mac == '0)

	// a hit comes from a lookup, which writes no slot
	`ARPC_ASSERT_IMP(a_hit_no_slot, clk, arst_n, rsp_valid && rsp_hit, rsp_slot_used == '0)

endmodule

bind arp_cache_table arpc_checker u_arpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_hit       (rsp.hit),
	.rsp_found_mac (rsp.found_mac),
	.rsp_slot_used (rsp.slot_used)
);
